[hw/rtl/tpfd_pkg.sv]
`default_nettype none

package tpfd_pkg;

  localparam int unsigned FB_DEFAULT = 32;

  typedef logic signed [63:0] fx_t;

  localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  // constants at 60 fraction bits
  localparam logic [63:0] K60_158  = 64'd1821615977278818222;
  localparam logic [63:0] K60_0213 = 64'd24557228048125841;
  localparam logic [63:0] K60_PSQ  = 64'd260509717115307;
  localparam logic [63:0] K60_08   = 64'd922337203685477581;
  localparam logic [63:0] K60_002  = 64'd23058430092136940;
  localparam logic [63:0] K60_004  = 64'd46116860184273879;
  localparam logic [63:0] K60_081  = 64'd933866418731546051;

  typedef enum logic [1:0] {
    CFG_SECTION_LENGTH = 2'd0,
    CFG_TUBE_DIAMETER  = 2'd1,
    CFG_MASS_VELOCITY  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic f;
    fx_t  v;
  } fx_res_t;

  // everything an item carries down the pipeline
  typedef struct packed {
    logic fc;   // common fault
    logic fl;   // fault of the linear branch
    logic fp;   // fault of the parabolic branch
    fx_t  zeta;
    fx_t  p;
    fx_t  sv;
    fx_t  wv;
    fx_t  x;
    fx_t  ratio;
    fx_t  pi1;
    fx_t  fac;
    fx_t  tmp;
    fx_t  tpf;
    fx_t  xm;
    fx_t  den;
    fx_t  mb;
    fx_t  r1l;
    fx_t  ee;
    fx_t  kd;
    fx_t  num;
    fx_t  q2;
    fx_t  s1;
    fx_t  r1;
  } bnd_t;

  function automatic logic [63:0] mag(fx_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // round a 60 fraction bit constant half up to fb fraction bits
  function automatic fx_t kc(logic [63:0] c60, int unsigned fb);
    logic [63:0] s;
    s = (c60 + (64'd1 << (59 - fb))) >> (60 - fb);
    return fx_t'(s);
  endfunction

  function automatic fx_res_t from_raw(logic [63:0] v, int unsigned s);
    fx_res_t r;
    if (v > (64'(FX_MAX) >> s)) begin
      r.f = 1'b1;
      r.v = FX_MAX;
    end else begin
      r.f = 1'b0;
      r.v = fx_t'(v << s);
    end
    return r;
  endfunction

  function automatic fx_res_t sat_add(fx_t a, fx_t b);
    logic signed [64:0] s;
    fx_res_t r;
    s = 65'(a) + 65'(b);
    if (s > 65'(FX_MAX)) begin
      r.f = 1'b1;
      r.v = FX_MAX;
    end else if (s < -65'(FX_MAX)) begin
      r.f = 1'b1;
      r.v = -FX_MAX;
    end else begin
      r.f = 1'b0;
      r.v = s[63:0];
    end
    return r;
  endfunction

  function automatic fx_res_t sat_sub(fx_t a, fx_t b);
    return sat_add(a, -b);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tpfd_mul.sv]
`default_nettype none

module tpfd_mul import tpfd_pkg::*; #(
  parameter int unsigned FB = FB_DEFAULT,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire fx_t           a_i,
  input  wire fx_t           b_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output fx_t                res_o,
  output logic               fault_o,
  output logic [SW-1:0]      side_o
);

  logic [2:0]    vld_q;
  logic [SW-1:0] side1_q, side2_q, side3_q;
  logic [2:0]    neg_q;
  logic [63:0]   ma_q, mb_q;
  logic [63:0]   ll_q, lh_q, hl_q, hh_q;
  logic [127:0]  p_q;
  logic [127:0]  p_d;
  logic          ovf;
  logic [63:0]   m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[1:0], valid_i};
      valid_o <= vld_q[2];
    end
  end

  // 32x32 partial products, then one wide sum
  always_comb begin
    p_d = {64'd0, ll_q} + ({64'd0, lh_q} << 32) + ({64'd0, hl_q} << 32) + {hh_q, 64'd0};
  end

  always_comb begin
    ovf = (p_q >> (FB + 63)) != '0;
    m   = ovf ? 64'(FX_MAX) : p_q[FB+63 -: 64];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q    <= mag(a_i);
      mb_q    <= mag(b_i);
      neg_q   <= {neg_q[1:0], a_i[63] ^ b_i[63]};
      side1_q <= side_i;
      ll_q    <= 64'(ma_q[31:0])  * 64'(mb_q[31:0]);
      lh_q    <= 64'(ma_q[63:32]) * 64'(mb_q[31:0]);
      hl_q    <= 64'(ma_q[31:0])  * 64'(mb_q[63:32]);
      hh_q    <= 64'(ma_q[63:32]) * 64'(mb_q[63:32]);
      side2_q <= side1_q;
      p_q     <= p_d;
      side3_q <= side2_q;
      res_o   <= neg_q[2] ? fx_t'(-m) : fx_t'(m);
      fault_o <= ovf;
      side_o  <= side3_q;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tpfd_div.sv]
`default_nettype none

module tpfd_div import tpfd_pkg::*; #(
  parameter int unsigned FB = FB_DEFAULT,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire fx_t           a_i,
  input  wire fx_t           b_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output fx_t                res_o,
  output logic               fault_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned NIT = 64;

  logic [63:0]   rem_q  [0:NIT];
  logic [63:0]   lo_q   [0:NIT];
  logic [63:0]   quo_q  [0:NIT];
  logic [63:0]   dvs_q  [0:NIT];
  logic          zero_q [0:NIT];
  logic          ovf_q  [0:NIT];
  logic          neg_q  [0:NIT];
  logic          aneg_q [0:NIT];
  logic [SW-1:0] side_q [0:NIT];
  logic [NIT:0]  vld_q;

  logic [63:0] ma, mb, hi;
  fx_t         res_d;
  logic        flt_d;

  always_comb begin
    ma = mag(a_i);
    mb = mag(b_i);
    hi = ma >> (64 - FB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[NIT-1:0], valid_i};
      valid_o <= vld_q[NIT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= hi;
      lo_q[0]   <= ma << FB;
      quo_q[0]  <= '0;
      dvs_q[0]  <= mb;
      zero_q[0] <= (b_i == '0);
      ovf_q[0]  <= (hi >= mb);
      neg_q[0]  <= a_i[63] ^ b_i[63];
      aneg_q[0] <= a_i[63];
      side_q[0] <= side_i;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= NIT; k++) begin : g_it
    logic [64:0] t;
    logic [63:0] rem_d;
    logic        qb;

    always_comb begin
      t = {rem_q[k-1], lo_q[k-1][63]};
      if (t >= {1'b0, dvs_q[k-1]}) begin
        qb    = 1'b1;
        rem_d = 64'(t - {1'b0, dvs_q[k-1]});
      end else begin
        qb    = 1'b0;
        rem_d = t[63:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        lo_q[k]   <= lo_q[k-1] << 1;
        quo_q[k]  <= {quo_q[k-1][62:0], qb};
        dvs_q[k]  <= dvs_q[k-1];
        zero_q[k] <= zero_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        aneg_q[k] <= aneg_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_comb begin
    if (zero_q[NIT]) begin
      flt_d = 1'b1;
      res_d = aneg_q[NIT] ? -FX_MAX : FX_MAX;
    end else if (ovf_q[NIT] || (quo_q[NIT] > 64'(FX_MAX))) begin
      flt_d = 1'b1;
      res_d = neg_q[NIT] ? -FX_MAX : FX_MAX;
    end else begin
      flt_d = 1'b0;
      res_d = neg_q[NIT] ? fx_t'(-quo_q[NIT]) : fx_t'(quo_q[NIT]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o   <= res_d;
      fault_o <= flt_d;
      side_o  <= side_q[NIT];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/two_phase_friction_pressure_drop.sv]
`default_nettype none

// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o   loss_coefficient_i .. quality_i
// out      output     out_valid_o / out_stall_i pressure_drop_o, fault_o
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one item may enter every cycle while in_stall_o is low; a result follows its transfer in through
// three 66-stage radix-2 dividers and twelve 4-stage multipliers in series
// a two-entry output queue takes results; the pipeline freezes only while it is full
// reset clears valid bits and the queue and loads the register defaults

module two_phase_friction_pressure_drop import tpfd_pkg::*; #(
  parameter int unsigned INTERNAL_FRAC_BITS = FB_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] loss_coefficient_i,
  input  wire logic [20:0] pressure_mpa_i,
  input  wire logic [25:0] steam_vol_in_i,
  input  wire logic [25:0] steam_vol_out_i,
  input  wire logic [25:0] water_vol_in_i,
  input  wire logic [25:0] water_vol_out_i,
  input  wire logic [16:0] quality_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [47:0]      pressure_drop_o,
  output logic             fault_o
);

  localparam int unsigned FB = INTERNAL_FRAC_BITS;
  localparam int unsigned BW = $bits(bnd_t);
  localparam fx_t ONE    = fx_t'(64'd1 << FB);
  localparam fx_t K_158  = kc(K60_158, FB);
  localparam fx_t K_0213 = kc(K60_0213, FB);
  localparam fx_t K_PSQ  = kc(K60_PSQ, FB);
  localparam fx_t K_08   = kc(K60_08, FB);
  localparam fx_t K_002  = kc(K60_002, FB);
  localparam fx_t K_004  = kc(K60_004, FB);
  localparam fx_t K_081  = kc(K60_081, FB);

  logic en;

  // ---------------- configuration ----------------
  logic [31:0] sec_len_q, tube_dia_q;
  logic [23:0] mass_vel_q;
  fx_t         len_fx_q, dia_fx_q, g_fx_q;
  logic        cfg_flt_q;
  fx_res_t     len_c, dia_c, g_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_len_q  <= 32'd65536;
      tube_dia_q <= 32'd838861;
      mass_vel_q <= 24'd256000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SECTION_LENGTH: sec_len_q  <= cfg_wdata_i;
        CFG_TUBE_DIAMETER:  tube_dia_q <= cfg_wdata_i;
        CFG_MASS_VELOCITY:  mass_vel_q <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_c = from_raw(64'(sec_len_q), FB - 16);
    dia_c = from_raw(64'(tube_dia_q), FB - 24);
    g_c   = from_raw(64'(mass_vel_q), FB - 8);
  end

  always_ff @(posedge clk_i) begin
    len_fx_q  <= len_c.v;
    dia_fx_q  <= dia_c.v;
    g_fx_q    <= g_c.v;
    cfg_flt_q <= len_c.f | dia_c.f | g_c.f;
  end

  // ---------------- input conversion ----------------
  bnd_t    b0_d, b0_q;
  logic    v0_q;
  fx_res_t c_z, c_p, c_sv, c_wv, c_x;

  always_comb begin
    c_z  = from_raw(64'(loss_coefficient_i), FB - 16);
    c_p  = from_raw(64'(pressure_mpa_i), FB - 16);
    c_sv = from_raw(64'(27'(steam_vol_in_i) + 27'(steam_vol_out_i)), FB - 24);
    c_wv = from_raw(64'(27'(water_vol_in_i) + 27'(water_vol_out_i)), FB - 24);
    c_x  = from_raw(64'(quality_i), FB - 16);
    b0_d      = '0;
    b0_d.zeta = c_z.v;
    b0_d.p    = c_p.v;
    b0_d.sv   = c_sv.v;
    b0_d.wv   = c_wv.v;
    b0_d.x    = c_x.v;
    b0_d.fc   = c_z.f | c_p.f | c_sv.f | c_wv.f | c_x.f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) b0_q <= b0_d;
  end

  // ---------------- density ratio ----------------
  logic v1; fx_t r1r; logic r1f; logic [BW-1:0] s1;
  tpfd_div #(.FB(FB), .SW(BW)) u_ratio (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q), .a_i(b0_q.sv), .b_i(b0_q.wv),
    .side_i(b0_q), .valid_o(v1), .res_o(r1r), .fault_o(r1f), .side_o(s1)
  );

  bnd_t b1_d, b1_q; logic v1_q; fx_res_t t_pi1;
  always_comb begin
    b1_d       = bnd_t'(s1);
    t_pi1      = sat_sub(r1r, ONE);
    b1_d.ratio = r1r;
    b1_d.pi1   = t_pi1.v;
    b1_d.fc    = b1_d.fc | r1f | t_pi1.f;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v1;
  end
  always_ff @(posedge clk_i) begin
    if (en) b1_q <= b1_d;
  end

  // ---------------- pressure factor ----------------
  logic v2; fx_t r2a, r2b; logic f2a, f2b; logic [BW-1:0] s2;
  tpfd_mul #(.FB(FB), .SW(BW)) u_kp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q), .a_i(K_0213), .b_i(b1_q.p),
    .side_i(b1_q), .valid_o(v2), .res_o(r2a), .fault_o(f2a), .side_o(s2)
  );
  tpfd_mul #(.FB(FB), .SW(1)) u_kpsq (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q), .a_i(K_PSQ), .b_i(b1_q.p),
    .side_i(1'b0), .valid_o(), .res_o(r2b), .fault_o(f2b), .side_o()
  );

  bnd_t b2_d, b2_q; logic v2_q; fx_res_t t_fac;
  always_comb begin
    b2_d     = bnd_t'(s2);
    t_fac    = sat_sub(K_158, r2a);
    b2_d.fac = t_fac.v;
    b2_d.tmp = r2b;
    b2_d.fc  = b2_d.fc | f2a | f2b | t_fac.f;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v2;
  end
  always_ff @(posedge clk_i) begin
    if (en) b2_q <= b2_d;
  end

  logic v3; fx_t r3; logic f3; logic [BW-1:0] s3;
  tpfd_mul #(.FB(FB), .SW(BW)) u_psq (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q), .a_i(b2_q.tmp), .b_i(b2_q.p),
    .side_i(b2_q), .valid_o(v3), .res_o(r3), .fault_o(f3), .side_o(s3)
  );

  bnd_t b3_d, b3_q; logic v3_q; fx_res_t t_fac2;
  always_comb begin
    b3_d     = bnd_t'(s3);
    t_fac2   = sat_sub(b3_d.fac, r3);
    b3_d.fac = t_fac2.v;
    b3_d.fc  = b3_d.fc | f3 | t_fac2.f;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v3;
  end
  always_ff @(posedge clk_i) begin
    if (en) b3_q <= b3_d;
  end

  logic v4; fx_t r4; logic f4; logic [BW-1:0] s4;
  tpfd_mul #(.FB(FB), .SW(BW)) u_tpf (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .a_i(b3_q.fac), .b_i(b3_q.pi1),
    .side_i(b3_q), .valid_o(v4), .res_o(r4), .fault_o(f4), .side_o(s4)
  );

  bnd_t b4_d, b4_q; logic v4_q; fx_res_t t_den0, t_xm;
  always_comb begin
    b4_d     = bnd_t'(s4);
    t_den0   = sat_add(ONE, r4);
    t_xm     = sat_sub(b4_d.x, K_08);
    b4_d.tpf = r4;
    b4_d.den = t_den0.v;
    b4_d.xm  = t_xm.v;
    b4_d.fc  = b4_d.fc | f4;
    b4_d.fp  = b4_d.fp | t_den0.f | t_xm.f;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v4;
  end
  always_ff @(posedge clk_i) begin
    if (en) b4_q <= b4_d;
  end

  // ---------------- branches ----------------
  logic v5; fx_t r5e, r5f; logic f5e, f5f; logic [BW-1:0] s5;
  tpfd_mul #(.FB(FB), .SW(BW)) u_tx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .a_i(b4_q.tpf), .b_i(b4_q.x),
    .side_i(b4_q), .valid_o(v5), .res_o(r5e), .fault_o(f5e), .side_o(s5)
  );
  tpfd_mul #(.FB(FB), .SW(1)) u_k002 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .a_i(K_002), .b_i(b4_q.tpf),
    .side_i(1'b0), .valid_o(), .res_o(r5f), .fault_o(f5f), .side_o()
  );

  bnd_t b5_d, b5_q; logic v5_q; fx_res_t t_r1l, t_den;
  always_comb begin
    b5_d     = bnd_t'(s5);
    t_r1l    = sat_add(ONE, r5e);
    t_den    = sat_sub(b5_d.den, b5_d.ratio);
    b5_d.r1l = t_r1l.v;
    b5_d.den = t_den.v;
    b5_d.mb  = r5f;
    b5_d.fl  = b5_d.fl | f5e | t_r1l.f;
    b5_d.fp  = b5_d.fp | f5f | t_den.f;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v5;
  end
  always_ff @(posedge clk_i) begin
    if (en) b5_q <= b5_d;
  end

  logic v6; fx_t r6; logic f6; logic [BW-1:0] s6;
  tpfd_mul #(.FB(FB), .SW(BW)) u_xd (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q), .a_i(b5_q.xm), .b_i(b5_q.den),
    .side_i(b5_q), .valid_o(v6), .res_o(r6), .fault_o(f6), .side_o(s6)
  );

  bnd_t b6_d, b6_q; logic v6_q; fx_res_t t_e;
  always_comb begin
    b6_d     = bnd_t'(s6);
    t_e      = sat_sub(r6, b6_d.mb);
    b6_d.tmp = t_e.v;
    b6_d.fp  = b6_d.fp | f6 | t_e.f;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v6;
  end
  always_ff @(posedge clk_i) begin
    if (en) b6_q <= b6_d;
  end

  logic v7; fx_t r7h, r7i, r7j, r7k; logic f7h, f7i, f7j, f7k; logic [BW-1:0] s7;
  tpfd_mul #(.FB(FB), .SW(BW)) u_ee (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .a_i(b6_q.tmp), .b_i(b6_q.tmp),
    .side_i(b6_q), .valid_o(v7), .res_o(r7h), .fault_o(f7h), .side_o(s7)
  );
  tpfd_mul #(.FB(FB), .SW(1)) u_kd (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .a_i(K_004), .b_i(b6_q.den),
    .side_i(1'b0), .valid_o(), .res_o(r7i), .fault_o(f7i), .side_o()
  );
  tpfd_mul #(.FB(FB), .SW(1)) u_n1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .a_i(K_081), .b_i(b6_q.tpf),
    .side_i(1'b0), .valid_o(), .res_o(r7j), .fault_o(f7j), .side_o()
  );
  tpfd_mul #(.FB(FB), .SW(1)) u_n2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .a_i(K_08), .b_i(b6_q.pi1),
    .side_i(1'b0), .valid_o(), .res_o(r7k), .fault_o(f7k), .side_o()
  );

  bnd_t b7_d, b7_q; logic v7_q; fx_res_t t_num;
  always_comb begin
    b7_d     = bnd_t'(s7);
    t_num    = sat_sub(r7j, r7k);
    b7_d.ee  = r7h;
    b7_d.kd  = r7i;
    b7_d.num = t_num.v;
    b7_d.fp  = b7_d.fp | f7h | f7i | f7j | f7k | t_num.f;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v7;
  end
  always_ff @(posedge clk_i) begin
    if (en) b7_q <= b7_d;
  end

  logic v8; fx_t r8l, r8m; logic f8l, f8m; logic [BW-1:0] s8;
  tpfd_div #(.FB(FB), .SW(BW)) u_t1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v7_q), .a_i(b7_q.ee), .b_i(b7_q.kd),
    .side_i(b7_q), .valid_o(v8), .res_o(r8l), .fault_o(f8l), .side_o(s8)
  );
  tpfd_div #(.FB(FB), .SW(1)) u_nd (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v7_q), .a_i(b7_q.num), .b_i(b7_q.den),
    .side_i(1'b0), .valid_o(), .res_o(r8m), .fault_o(f8m), .side_o()
  );

  bnd_t b8_d, b8_q; logic v8_q; fx_res_t t_s1;
  always_comb begin
    b8_d    = bnd_t'(s8);
    t_s1    = sat_sub(ONE, r8l);
    b8_d.s1 = t_s1.v;
    b8_d.q2 = r8m;
    b8_d.fp = b8_d.fp | f8l | f8m | t_s1.f;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (en) v8_q <= v8;
  end
  always_ff @(posedge clk_i) begin
    if (en) b8_q <= b8_d;
  end

  logic v9; fx_t r9; logic f9; logic [BW-1:0] s9;
  tpfd_mul #(.FB(FB), .SW(BW)) u_w (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v8_q), .a_i(b8_q.tpf), .b_i(b8_q.q2),
    .side_i(b8_q), .valid_o(v9), .res_o(r9), .fault_o(f9), .side_o(s9)
  );

  // linear form strictly below quality 0.8
  bnd_t b9_d, b9_q; logic v9_q; fx_res_t t_r1p; logic lin;
  always_comb begin
    b9_d  = bnd_t'(s9);
    t_r1p = sat_add(b9_d.s1, r9);
    lin   = (b9_d.x < K_08);
    b9_d.r1 = lin ? b9_d.r1l : t_r1p.v;
    b9_d.fc = b9_d.fc | (lin ? b9_d.fl : (b9_d.fp | f9 | t_r1p.f));
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else if (en) v9_q <= v9;
  end
  always_ff @(posedge clk_i) begin
    if (en) b9_q <= b9_d;
  end

  // ---------------- scaling ----------------
  logic v10; fx_t r10; logic f10; logic [BW-1:0] s10; bnd_t s10m;
  tpfd_mul #(.FB(FB), .SW(BW)) u_zeta (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v9_q), .a_i(b9_q.r1), .b_i(b9_q.zeta),
    .side_i(b9_q), .valid_o(v10), .res_o(r10), .fault_o(f10), .side_o(s10)
  );
  always_comb begin
    s10m    = bnd_t'(s10);
    s10m.fc = s10m.fc | f10;
  end

  logic v11; fx_t r11; logic f11; logic [BW-1:0] s11; bnd_t s11m;
  tpfd_mul #(.FB(FB), .SW(BW)) u_len (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v10), .a_i(r10), .b_i(len_fx_q),
    .side_i(s10m), .valid_o(v11), .res_o(r11), .fault_o(f11), .side_o(s11)
  );
  always_comb begin
    s11m    = bnd_t'(s11);
    s11m.fc = s11m.fc | f11;
  end

  logic v12; fx_t r12; logic f12; logic [BW-1:0] s12; bnd_t s12m;
  tpfd_div #(.FB(FB), .SW(BW)) u_dia (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v11), .a_i(r11), .b_i(dia_fx_q),
    .side_i(s11m), .valid_o(v12), .res_o(r12), .fault_o(f12), .side_o(s12)
  );
  always_comb begin
    s12m    = bnd_t'(s12);
    s12m.fc = s12m.fc | f12;
  end

  logic v13; fx_t r13; logic f13; logic [BW-1:0] s13;
  tpfd_mul #(.FB(FB), .SW(BW)) u_wv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v12), .a_i(r12), .b_i(s12m.wv),
    .side_i(s12m), .valid_o(v13), .res_o(r13), .fault_o(f13), .side_o(s13)
  );

  // divide by four: magnitude shifted, never saturates
  bnd_t b13_d, b13_q; logic v13_q; logic [63:0] qm;
  always_comb begin
    b13_d     = bnd_t'(s13);
    qm        = mag(r13) >> 2;
    b13_d.tmp = r13[63] ? fx_t'(-qm) : fx_t'(qm);
    b13_d.fc  = b13_d.fc | f13;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v13_q <= 1'b0;
    else if (en) v13_q <= v13;
  end
  always_ff @(posedge clk_i) begin
    if (en) b13_q <= b13_d;
  end

  logic v14; fx_t r14; logic f14; logic [BW-1:0] s14; bnd_t s14m;
  tpfd_mul #(.FB(FB), .SW(BW)) u_g1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v13_q), .a_i(b13_q.tmp), .b_i(g_fx_q),
    .side_i(b13_q), .valid_o(v14), .res_o(r14), .fault_o(f14), .side_o(s14)
  );
  always_comb begin
    s14m    = bnd_t'(s14);
    s14m.fc = s14m.fc | f14;
  end

  logic v15; fx_t r15; logic f15; logic [BW-1:0] s15; bnd_t s15m;
  tpfd_mul #(.FB(FB), .SW(BW)) u_g2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v14), .a_i(r14), .b_i(g_fx_q),
    .side_i(s14m), .valid_o(v15), .res_o(r15), .fault_o(f15), .side_o(s15)
  );
  always_comb begin
    s15m = bnd_t'(s15);
  end

  // ---------------- output format ----------------
  logic fin_v_q; fx_t fin_dp_q; logic fin_f_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fin_v_q <= 1'b0;
    else if (en) fin_v_q <= v15;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_dp_q <= r15;
      fin_f_q  <= s15m.fc | f15;
    end
  end

  logic [63:0] om;
  logic [47:0] opd;
  logic        osat;
  always_comb begin
    om   = mag(fin_dp_q) >> (FB - 8);
    osat = om > 64'h0000_7FFF_FFFF_FFFF;
    if (osat) om = 64'h0000_7FFF_FFFF_FFFF;
    opd  = fin_dp_q[63] ? 48'(-om[47:0]) : om[47:0];
  end

  // two-entry queue decouples the output from the pipeline
  logic [47:0] ent_pd_q [0:1];
  logic        ent_f_q  [0:1];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;
  assign push       = en && fin_v_q;
  assign pop        = (cnt_q != 2'd0) && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_pd_q[wr_ptr_q] <= opd;
      ent_f_q[wr_ptr_q]  <= fin_f_q | osat | cfg_flt_q;
    end
  end

  assign out_valid_o     = (cnt_q != 2'd0);
  assign pressure_drop_o = ent_pd_q[rd_ptr_q];
  assign fault_o         = ent_f_q[rd_ptr_q];

endmodule

`default_nettype wire
